>>> rtl/assert_macros.svh
// Assertion macros used by the checker file of the decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define U8D_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("utf8 decoder assertion failed");

// Clocked assertion that is checked during reset as well.
`define U8D_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("utf8 decoder reset assertion failed");

`endif

>>> rtl/u8d_pkg.sv
// Shared types and constants of the UTF-8 stream decoder.
package u8d_pkg;

  localparam int CP_W  = 31;
  localparam int LEN_W = 3;
  localparam int ST_W  = 2;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_ILLEGAL = 2'd1;
  localparam logic [ST_W-1:0] ST_TOOFEW  = 2'd2;

  // One classified byte as it travels from the front end to the back end
  typedef struct packed {
    logic [7:0]       data_byte;
    logic             eob;
    logic             is_ascii;
    logic             bad_lead;
    logic             is_cont;
    logic [LEN_W-1:0] lead_len;
    logic [4:0]       lead_bits;
  } tok_t;

endpackage

>>> rtl/u8d_if.sv
// Channel interfaces of the UTF-8 stream decoder: byte input and code point output.
interface u8d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface u8d_out_if;
  logic        valid;
  logic        ready;
  logic [30:0] code_point;
  logic [2:0]  char_length;
  logic [1:0]  status;

  modport source (output valid, output code_point, output char_length, output status,
                  input ready);
  modport sink   (input valid, input code_point, input char_length, input status,
                  output ready);
endinterface

>>> rtl/u8d_front.sv
// Front end: accepts input bytes and classifies each one for the back end.
module u8d_front
  import u8d_pkg::*;
(
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_buffer,
  input  logic       q_full,
  output logic       q_push,
  output tok_t       q_tok
);

  // Accept while the queue has room and reset is released
  assign in_ready = rst_n && !q_full;
  assign q_push   = in_valid && in_ready;

  // Classify the byte both as a possible lead and as a possible continuation
  always_comb begin
    q_tok           = '0;
    q_tok.data_byte = in_data_byte;
    q_tok.eob       = in_end_of_buffer;
    q_tok.is_ascii  = !in_data_byte[7];
    q_tok.bad_lead  = (in_data_byte[7] && in_data_byte < 8'hC2) || in_data_byte >= 8'hFE;
    q_tok.is_cont   = in_data_byte[7:6] == 2'b10;
    priority if (in_data_byte < 8'hE0) begin
      q_tok.lead_len  = 3'd2;
      q_tok.lead_bits = in_data_byte[4:0];
    end else if (in_data_byte < 8'hF0) begin
      q_tok.lead_len  = 3'd3;
      q_tok.lead_bits = {1'b0, in_data_byte[3:0]};
    end else if (in_data_byte < 8'hF8) begin
      q_tok.lead_len  = 3'd4;
      q_tok.lead_bits = {2'b0, in_data_byte[2:0]};
    end else if (in_data_byte < 8'hFC) begin
      q_tok.lead_len  = 3'd5;
      q_tok.lead_bits = {3'b0, in_data_byte[1:0]};
    end else begin
      q_tok.lead_len  = 3'd6;
      q_tok.lead_bits = {4'b0, in_data_byte[0]};
    end
  end

endmodule

>>> rtl/u8d_fifo.sv
// Short queue of classified bytes between the front end and the back end.
module u8d_fifo
  import u8d_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  tok_t push_tok,
  output logic full,
  input  logic pop,
  output logic pop_valid,
  output tok_t pop_tok
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tok_t             mem_r [DEPTH];
  logic [IDX_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [IDX_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = count_r == CNT_W'(DEPTH);
  assign pop_valid = count_r != '0;
  assign pop_tok   = mem_r[rd_ptr_r];

  // Advance pointers with wrap, track fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule

>>> rtl/u8d_back.sv
// Back end: assembles sequences from classified bytes and holds the result register.
module u8d_back
  import u8d_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  tok_t             q_tok,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [CP_W-1:0]  out_code_point,
  output logic [LEN_W-1:0] out_char_length,
  output logic [ST_W-1:0]  out_status
);

  logic [LEN_W-1:0] exp_r, exp_nxt;
  logic [LEN_W-1:0] seen_r, seen_nxt;
  logic [CP_W-1:0]  acc_r, acc_nxt;
  logic [7:0]       lead_r, lead_nxt;
  logic [7:0]       second_r, second_nxt;
  logic             cok_r, cok_nxt;

  logic             out_valid_r;
  logic [CP_W-1:0]  cp_r;
  logic [LEN_W-1:0] len_r;
  logic [ST_W-1:0]  st_r;

  logic             emit;
  logic [CP_W-1:0]  res_cp;
  logic [LEN_W-1:0] res_len;
  logic [ST_W-1:0]  res_st;
  logic             overlong;

  // Take the next byte whenever the result register is free or being drained
  assign q_pop = q_valid && (!out_valid_r || out_ready);

  // Decode one byte against the current sequence state
  always_comb begin
    exp_nxt    = exp_r;
    seen_nxt   = seen_r;
    acc_nxt    = acc_r;
    lead_nxt   = lead_r;
    second_nxt = second_r;
    cok_nxt    = cok_r;
    emit       = 1'b0;
    res_cp     = '0;
    res_len    = '0;
    res_st     = ST_OK;
    overlong   = 1'b0;
    if (exp_r == '0) begin
      priority if (q_tok.is_ascii) begin
        emit    = 1'b1;
        res_cp  = CP_W'(q_tok.data_byte);
        res_len = 3'd1;
      end else if (q_tok.bad_lead) begin
        emit   = 1'b1;
        res_st = ST_ILLEGAL;
      end else if (q_tok.eob) begin
        emit   = 1'b1;
        res_st = ST_TOOFEW;
      end else begin
        exp_nxt    = q_tok.lead_len;
        seen_nxt   = 3'd1;
        lead_nxt   = q_tok.data_byte;
        second_nxt = '0;
        cok_nxt    = 1'b1;
        acc_nxt    = CP_W'(q_tok.lead_bits);
      end
    end else begin
      cok_nxt    = cok_r && q_tok.is_cont;
      second_nxt = (seen_r == 3'd1) ? q_tok.data_byte : second_r;
      acc_nxt    = {acc_r[CP_W-7:0], q_tok.data_byte[5:0]};
      seen_nxt   = seen_r + 3'd1;
      overlong   = (lead_r == 8'hE0 && second_nxt < 8'hA0) ||
                   (lead_r == 8'hF0 && second_nxt < 8'h90) ||
                   (lead_r == 8'hF8 && second_nxt < 8'h88) ||
                   (lead_r == 8'hFC && second_nxt < 8'h84);
      priority if (seen_nxt >= exp_r) begin
        emit    = 1'b1;
        exp_nxt = '0;
        if (cok_nxt && !overlong) begin
          res_cp  = acc_nxt;
          res_len = exp_r;
        end else begin
          res_st = ST_ILLEGAL;
        end
      end else if (q_tok.eob) begin
        emit    = 1'b1;
        exp_nxt = '0;
        res_st  = ST_TOOFEW;
      end else begin
        emit = 1'b0;
      end
    end
  end

  // Advance sequence state on each popped byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r  <= '0;
      seen_r <= '0;
    end else if (q_pop) begin
      exp_r  <= exp_nxt;
      seen_r <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      acc_r    <= acc_nxt;
      lead_r   <= lead_nxt;
      second_r <= second_nxt;
      cok_r    <= cok_nxt;
    end
  end

  // Load or drain the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= q_pop && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      cp_r  <= res_cp;
      len_r <= res_len;
      st_r  <= res_st;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_code_point  = cp_r;
  assign out_char_length = len_r;
  assign out_status      = st_r;

endmodule

>>> rtl/utf8_stream_decoder.sv
// Top level of the UTF-8 stream decoder (one to six byte sequences, 31-bit code points).
//
// Usage:
//   in_ch carries one byte per transaction together with an end-of-buffer flag.
//   out_ch carries one result per finished character: code point, length, status
//   (ok, illegal sequence, or too few bytes when the buffer ends mid-sequence).
//   ASCII bytes and bad lead bytes give a result on their own; a lead byte opens a
//   sequence that gives one result when its last continuation byte arrives.
// Path: an accepted byte is written into the queue, then decoded by the back end and
//   loaded into its result register, which drives out_ch.
// Throughput: one byte per cycle while out_ch is not stalled, as the back end steps its
//   sequence state on each popped byte; results per cycle are at most one.
// Reset: rst_n low empties the queue, clears the output valid and returns the
//   decoder to waiting for a lead byte; in_ch.ready is low during reset.
// Stall: when out_ch.ready is low the result holds in the output register and
//   bytes keep filling the queue of QUEUE_DEPTH entries; in_ch.ready drops once
//   it is full.
module utf8_stream_decoder
  import u8d_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic  clk,
  input  logic  rst_n,
  u8d_in_if.sink    in_ch,
  u8d_out_if.source out_ch
);

  logic q_full;
  logic q_push;
  tok_t q_push_tok;
  logic q_pop;
  logic q_valid;
  tok_t q_pop_tok;

  u8d_front u_front (
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_data_byte     (in_ch.data_byte),
    .in_end_of_buffer (in_ch.end_of_buffer),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_tok            (q_push_tok)
  );

  u8d_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_tok  (q_push_tok),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_tok   (q_pop_tok)
  );

  u8d_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_tok           (q_pop_tok),
    .q_pop           (q_pop),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_code_point  (out_ch.code_point),
    .out_char_length (out_ch.char_length),
    .out_status      (out_ch.status)
  );

endmodule

>>> rtl/u8d_checker.sv
// Port-level checker of the UTF-8 stream decoder and its bind to the top level.
`include "assert_macros.svh"

module u8d_checker
  import u8d_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [CP_W-1:0]  code_point,
  input logic [LEN_W-1:0] char_length,
  input logic [ST_W-1:0]  status
);

  // Hold a stalled result
  `U8D_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(code_point) && $stable(char_length) && $stable(status))

  // Report only defined status codes
  `U8D_ASSERT(a_status_code, clk, rst_n, out_valid |-> (status == ST_OK || status == ST_ILLEGAL || status == ST_TOOFEW))

  // Give a length of one to six bytes for a decoded character
  `U8D_ASSERT(a_ok_length, clk, rst_n, out_valid && status == ST_OK |-> char_length != 3'd0 && char_length != 3'd7)

  // Zero code point and length on an error result
  `U8D_ASSERT(a_err_zero, clk, rst_n, out_valid && status != ST_OK |-> code_point == '0 && char_length == '0)

  // Refuse input during reset and come out of reset with no result pending
  `U8D_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |-> !in_ready ##1 !out_valid)

endmodule

bind utf8_stream_decoder u8d_checker u_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .code_point  (out_ch.code_point),
  .char_length (out_ch.char_length),
  .status      (out_ch.status)
);
